/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

/* rtl/v3n_pkg.sv */
// ---------------------------------------------------------------------------
// v3n_pkg
// Types shared by the vector normalizer cells.
// ---------------------------------------------------------------------------
package v3n_pkg;
	typedef struct packed {
		logic valid;
		logic zero;
		logic neg_x;
		logic neg_y;
		logic neg_z;
	} v3n_ctl_t;
endpackage

/* rtl/v3n_sqrt_cell.sv */
// ---------------------------------------------------------------------------
// v3n_sqrt_cell
// One restoring square-root digit step; registers the partial root.
// ---------------------------------------------------------------------------
module v3n_sqrt_cell #(
	parameter int SW = 64,
	parameter int RW = 32,
	parameter int MW = 24,
	parameter int P = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  v3n_pkg::v3n_ctl_t ctl_in,
	input  logic [SW-1:0] s_in,
	input  logic [RW-1:0] root_in,
	input  logic [RW+1:0] rem_in,
	input  logic [MW-1:0] mx_in, my_in, mz_in,
	output v3n_pkg::v3n_ctl_t ctl_out,
	output logic [SW-1:0] s_out,
	output logic [RW-1:0] root_out,
	output logic [RW+1:0] rem_out,
	output logic [MW-1:0] mx_out, my_out, mz_out
);
	import v3n_pkg::*;
	logic [1:0]    pair;
	logic [RW+1:0] r2, trial;
	always_comb begin
		pair = (P >= 0) ? s_in[(P >= 0 ? 2*P : 0) +: 2] : 2'b00;
		r2 = {rem_in[RW-1:0], pair};
		trial = {root_in, 2'b01};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end
	always_ff @(posedge clk) begin
		s_out <= s_in;
		mx_out <= mx_in;
		my_out <= my_in;
		mz_out <= mz_in;
		if (r2 >= trial) begin
			rem_out <= r2 - trial;
			root_out <= {root_in[RW-2:0], 1'b1};
		end else begin
			rem_out <= r2;
			root_out <= {root_in[RW-2:0], 1'b0};
		end
	end
endmodule

/* rtl/v3n_div_cell.sv */
// ---------------------------------------------------------------------------
// v3n_div_cell
// One restoring division step for three numerators against a shared divisor.
// ---------------------------------------------------------------------------
module v3n_div_cell #(
	parameter int NW = 40,
	parameter int RW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  v3n_pkg::v3n_ctl_t ctl_in,
	input  logic [RW-1:0] d_in,
	input  logic [NW-1:0] nx_in, ny_in, nz_in,
	input  logic [RW:0]   rx_in, ry_in, rz_in,
	output v3n_pkg::v3n_ctl_t ctl_out,
	output logic [RW-1:0] d_out,
	output logic [NW-1:0] nx_out, ny_out, nz_out,
	output logic [RW:0]   rx_out, ry_out, rz_out
);
	import v3n_pkg::*;
	function automatic logic [RW+NW:0] step(logic [RW:0] r, logic [NW-1:0] n,
			logic [RW-1:0] d);
		logic [RW+1:0] t;
		t = {r, n[NW-1]};
		if (t >= {2'b00, d})
			step = {(RW+1)'(t - {2'b00, d}), n[NW-2:0], 1'b1};
		else
			step = {t[RW:0], n[NW-2:0], 1'b0};
	endfunction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end
	always_ff @(posedge clk) begin
		d_out <= d_in;
		{rx_out, nx_out} <= step(rx_in, nx_in, d_in);
		{ry_out, ny_out} <= step(ry_in, ny_in, d_in);
		{rz_out, nz_out} <= step(rz_in, nz_in, d_in);
	end
endmodule

/* rtl/vector3_normalize.sv */
// ---------------------------------------------------------------------------
// vector3_normalize
// Fixed-point 3D vector normalizer, one vector per cycle.
// ---------------------------------------------------------------------------
// Accepts a vector every cycle (busy is always low) and delivers each result
// with done high after the magnitude, square and sum registers, one cell per
// root digit (IN_WIDTH+1+FRAC_BITS cells), one cell per quotient bit
// (IN_WIDTH+2*FRAC_BITS cells) and one output register. The receiver
// cannot stall; results arrive in order, one per accepted vector.
module vector3_normalize #(
	parameter int IN_WIDTH = 16,
	parameter int FRAC_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [IN_WIDTH-1:0]   vec_x,
	input  logic [IN_WIDTH-1:0]   vec_y,
	input  logic [IN_WIDTH-1:0]   vec_z,
	output logic                  done,
	output logic [FRAC_BITS+1:0]  unit_x,
	output logic [FRAC_BITS+1:0]  unit_y,
	output logic [FRAC_BITS+1:0]  unit_z,
	output logic                  zero_length
);
	import v3n_pkg::*;
	localparam int MW = IN_WIDTH;
	localparam int SW = 2*IN_WIDTH + 2;
	localparam int PAIRS = IN_WIDTH + 1;
	localparam int NSQ = PAIRS + FRAC_BITS;
	localparam int RW = NSQ + 1;
	localparam int NW = MW + 2*FRAC_BITS;
	localparam int OW = FRAC_BITS + 2;

	assign busy = 1'b0;

	v3n_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [MW-1:0] mx_s1, my_s1, mz_s1, mx_s2, my_s2, mz_s2, mx_s3, my_s3, mz_s3;
	logic [2*MW-1:0] px_s2, py_s2, pz_s2;
	logic [SW-1:0] s_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1.valid <= start;
			ctl_s1.zero <= (vec_x == '0) && (vec_y == '0) && (vec_z == '0);
			ctl_s1.neg_x <= vec_x[IN_WIDTH-1];
			ctl_s1.neg_y <= vec_y[IN_WIDTH-1];
			ctl_s1.neg_z <= vec_z[IN_WIDTH-1];
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1 <= vec_x[IN_WIDTH-1] ? MW'(-vec_x) : vec_x;
		my_s1 <= vec_y[IN_WIDTH-1] ? MW'(-vec_y) : vec_y;
		mz_s1 <= vec_z[IN_WIDTH-1] ? MW'(-vec_z) : vec_z;
		px_s2 <= mx_s1 * mx_s1;
		py_s2 <= my_s1 * my_s1;
		pz_s2 <= mz_s1 * mz_s1;
		{mx_s2, my_s2, mz_s2} <= {mx_s1, my_s1, mz_s1};
		s_s3 <= SW'(px_s2) + SW'(py_s2) + SW'(pz_s2);
		{mx_s3, my_s3, mz_s3} <= {mx_s2, my_s2, mz_s2};
	end

	v3n_ctl_t      sc [NSQ+1];
	logic [SW-1:0] ss [NSQ+1];
	logic [RW-1:0] sr [NSQ+1];
	logic [RW+1:0] sm [NSQ+1];
	logic [MW-1:0] sx [NSQ+1], sy [NSQ+1], sz [NSQ+1];

	assign sc[0] = ctl_s3;
	assign ss[0] = s_s3;
	assign sr[0] = '0;
	assign sm[0] = '0;
	assign sx[0] = mx_s3;
	assign sy[0] = my_s3;
	assign sz[0] = mz_s3;

	for (genvar i = 0; i < NSQ; i++) begin : g_sq
		v3n_sqrt_cell #(.SW(SW), .RW(RW), .MW(MW), .P(PAIRS-1-i)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_in(sc[i]), .s_in(ss[i]), .root_in(sr[i]), .rem_in(sm[i]),
			.mx_in(sx[i]), .my_in(sy[i]), .mz_in(sz[i]),
			.ctl_out(sc[i+1]), .s_out(ss[i+1]), .root_out(sr[i+1]),
			.rem_out(sm[i+1]), .mx_out(sx[i+1]), .my_out(sy[i+1]), .mz_out(sz[i+1])
		);
	end

	v3n_ctl_t      dc [NW+1];
	logic [RW-1:0] dd [NW+1];
	logic [NW-1:0] dnx [NW+1], dny [NW+1], dnz [NW+1];
	logic [RW:0]   drx [NW+1], dry [NW+1], drz [NW+1];

	assign dc[0] = sc[NSQ];
	assign dd[0] = sr[NSQ];
	assign dnx[0] = {sx[NSQ], (2*FRAC_BITS)'(0)};
	assign dny[0] = {sy[NSQ], (2*FRAC_BITS)'(0)};
	assign dnz[0] = {sz[NSQ], (2*FRAC_BITS)'(0)};
	assign drx[0] = '0;
	assign dry[0] = '0;
	assign drz[0] = '0;

	for (genvar j = 0; j < NW; j++) begin : g_dv
		v3n_div_cell #(.NW(NW), .RW(RW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_in(dc[j]), .d_in(dd[j]),
			.nx_in(dnx[j]), .ny_in(dny[j]), .nz_in(dnz[j]),
			.rx_in(drx[j]), .ry_in(dry[j]), .rz_in(drz[j]),
			.ctl_out(dc[j+1]), .d_out(dd[j+1]),
			.nx_out(dnx[j+1]), .ny_out(dny[j+1]), .nz_out(dnz[j+1]),
			.rx_out(drx[j+1]), .ry_out(dry[j+1]), .rz_out(drz[j+1])
		);
	end

	v3n_ctl_t ce;
	logic [OW-1:0] qx, qy, qz;
	assign ce = dc[NW];
	assign qx = dnx[NW][OW-1:0];
	assign qy = dny[NW][OW-1:0];
	assign qz = dnz[NW][OW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ce.valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_length <= ce.zero;
		unit_x <= ce.zero ? '0 : (ce.neg_x ? OW'(-qx) : qx);
		unit_y <= ce.zero ? '0 : (ce.neg_y ? OW'(-qy) : qy);
		unit_z <= ce.zero ? '0 : (ce.neg_z ? OW'(-qz) : qz);
	end
endmodule

/* rtl/v3n_checker.sv */
// ---------------------------------------------------------------------------
// v3n_checker
// Port-level checks of the vector normalizer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module v3n_checker #(
	parameter int OW = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          busy,
	input logic          done,
	input logic [OW-1:0] unit_x,
	input logic [OW-1:0] unit_y,
	input logic [OW-1:0] unit_z,
	input logic          zero_length
);
	`ASSERT_IMPLIES(a_never_busy, clk, arst_n, 1'b1, !busy)
	`ASSERT_IMPLIES(a_zero_out, clk, arst_n, done && zero_length, unit_x == '0 && unit_y == '0 && unit_z == '0)
	`ASSERT_IMPLIES(a_mag_x, clk, arst_n, done, unit_x[OW-1] || unit_x <= (OW'(1) << (OW-2)))
	`ASSERT_IMPLIES(a_mag_y, clk, arst_n, done, unit_y[OW-1] || unit_y <= (OW'(1) << (OW-2)))
endmodule

bind vector3_normalize v3n_checker #(.OW(FRAC_BITS+2)) u_v3n_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .done(done),
	.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .zero_length(zero_length)
);

/* tb/vector3_normalize_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Normalized vector checker
// Watches vector transfers into the normalizer, predicts the unit vector for
// each one with exact integer arithmetic, and compares every delivered
// result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module vector3_normalize_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] vec_x,
	input  logic [15:0] vec_y,
	input  logic [15:0] vec_z,
	input  logic        done,
	input  logic [15:0] unit_x,
	input  logic [15:0] unit_y,
	input  logic [15:0] unit_z,
	input  logic        zero_length,
	output int          fail_count,
	output int          pending,
	output int          unit_count,
	output int          zero_count
);
	typedef struct packed {
		logic [15:0] ux;
		logic [15:0] uy;
		logic [15:0] uz;
		logic        zero;
	} unit_vec_t;

	unit_vec_t expected_units[$];

	function automatic logic [63:0] comp_mag(logic [15:0] c);
		return c[15] ? 64'(17'h10000 - {1'b0, c}) : 64'(c);
	endfunction

	function automatic logic [63:0] length_root(logic [63:0] s);
		logic [63:0] root;
		logic [63:0] rem;
		logic [63:0] pair;
		logic [63:0] trial;
		root = 0;
		rem = 0;
		for (int p = 24; p >= -14; p--) begin
			pair = (p >= 0) ? ((s >> (2 * p)) & 64'd3) : 64'd0;
			rem = (rem << 2) | pair;
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic unit_vec_t predict_unit(logic [15:0] x, logic [15:0] y,
			logic [15:0] z);
		logic [15:0] c [3];
		logic [63:0] m [3];
		logic [63:0] s;
		logic [63:0] len;
		logic [63:0] q [3];
		unit_vec_t u;
		c[0] = x;
		c[1] = y;
		c[2] = z;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = comp_mag(c[i]);
			s = s + m[i] * m[i];
		end
		if (s == 0) begin
			u = '{16'd0, 16'd0, 16'd0, 1'b1};
			return u;
		end
		len = length_root(s);
		for (int i = 0; i < 3; i++) begin
			q[i] = (m[i] << 28) / len;
			if (c[i][15])
				q[i] = 64'd0 - q[i];
		end
		u = '{q[0][15:0], q[1][15:0], q[2][15:0], 1'b0};
		return u;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $time);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		unit_count = 0;
		zero_count = 0;
	end

	always @(posedge clk) begin
		unit_vec_t want;
		if (arst_n) begin
			if (start && !busy)
				expected_units.push_back(predict_unit(vec_x, vec_y, vec_z));
			if (done) begin
				if (expected_units.size() == 0) begin
					report_mismatch("unexpected result", unit_x, 16'd0);
				end else begin
					want = expected_units.pop_front();
					if (unit_x !== want.ux)
						report_mismatch("unit_x", unit_x, want.ux);
					if (unit_y !== want.uy)
						report_mismatch("unit_y", unit_y, want.uy);
					if (unit_z !== want.uz)
						report_mismatch("unit_z", unit_z, want.uz);
					if (zero_length !== want.zero)
						report_mismatch("zero_length", 16'(zero_length), 16'(want.zero));
					unit_count++;
					if (want.zero)
						zero_count++;
				end
			end
			pending = expected_units.size();
		end
	end
endmodule

/* tb/vector3_normalize_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector normalizer test
// Drives directed corner vectors and then random vectors through the
// normalizer under several sender idling phases; the checker compares every
// result with its own prediction.
// ----------------------------------------------------------------------------
module vector3_normalize_test;
	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] vec_x;
	logic [15:0] vec_y;
	logic [15:0] vec_z;
	logic        done;
	logic [15:0] unit_x;
	logic [15:0] unit_y;
	logic [15:0] unit_z;
	logic        zero_length;
	int          fail_count;
	int          pending;
	int          unit_count;
	int          zero_count;
	int          idle_pct;
	int          sent;

	localparam int LATENCY = 3 + 16 + 1 + 14 + 16 + 28 + 1;

	vector3_normalize u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .done(done),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.zero_length(zero_length)
	);

	vector3_normalize_check u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .done(done),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.zero_length(zero_length), .fail_count(fail_count),
		.pending(pending), .unit_count(unit_count), .zero_count(zero_count)
	);

	always #1 clk = ~clk;

	// hold each vector until its transfer, idling between vectors at random
	task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(8)) - 4);
			3: return 16'($urandom_range(255)) ^ {16{$urandom_range(1) == 1}};
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int k;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		vec_x = '0;
		vec_y = '0;
		vec_z = '0;
		idle_pct = 0;
		sent = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_vector(16'h0000, 16'h0000, 16'h0000);
		send_vector(16'h8000, 16'h0000, 16'h0000);
		send_vector(16'h0000, 16'h8000, 16'h0000);
		send_vector(16'h0000, 16'h0000, 16'h8000);
		send_vector(16'h8000, 16'h8000, 16'h8000);
		send_vector(16'h7fff, 16'h7fff, 16'h7fff);
		send_vector(16'h7fff, 16'h8000, 16'h7fff);
		send_vector(16'h0001, 16'h0000, 16'h0000);
		send_vector(16'hffff, 16'h0000, 16'h0000);
		send_vector(16'h0001, 16'h0001, 16'h0001);
		send_vector(16'hffff, 16'h0001, 16'hffff);
		send_vector(16'h0003, 16'h0004, 16'h0000);
		send_vector(16'h0001, 16'h7fff, 16'h8000);
		send_vector(16'h5555, 16'haaaa, 16'h0000);
		send_vector(16'h0000, 16'h0000, 16'h0000);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: idle_pct = 0;
				1: idle_pct = 60;
				2: idle_pct = 28;
				default: idle_pct = 0;
			endcase
			for (k = 0; k < 260; k++) begin
				if ($urandom_range(49) == 0)
					send_vector(16'h0000, 16'h0000, 16'h0000);
				else
					send_vector(rand_comp(), rand_comp(), rand_comp());
			end
		end
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		$display("covered %0d vectors, %0d results checked, %0d zero-length",
			sent, unit_count, zero_count);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end
endmodule
